// ===== src/pru_pkg.sv =====
// Shared types, sizes and register codes of the pixel replicate upscaler.
// No dependencies; pru_seq, pru_emit and the top level import this package.
package pru_pkg;

   localparam int MAX_LINE_WIDTH = 512;
   localparam int MAX_SCALE      = 10;
   localparam int ROW_LIMIT      = 512;

   localparam int COL_W   = $clog2(MAX_LINE_WIDTH);
   localparam int SCALE_W = $clog2(MAX_SCALE + 1);
   localparam int ROW_W   = $clog2(ROW_LIMIT);

   localparam int PIXEL_W     = 32;
   localparam int CHAN_W      = 8;
   localparam int CFG_SCALE_W = 4;
   localparam int CFG_WIDTH_W = 10;
   localparam int CFG_HEIGHT_W = 10;
   localparam int CFG_KEEP_W  = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE  = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2,
      CSR_KEEP   = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic               mode;
      logic [PIXEL_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               last;
   } rsp_type;

   // Per-beat controls from the sequencer to the line buffer and the output side.
   typedef struct packed {
      logic [COL_W-1:0]   col;
      logic               dark;
      logic [CHAN_W-1:0]  keep;
      logic [SCALE_W-1:0] copies;
   } slot_type;

   function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                    input logic [CHAN_W-1:0] k);
      logic [2*CHAN_W-1:0] prod;
      prod = c * k;
      return prod[2*CHAN_W-1:CHAN_W];
   endfunction

   function automatic logic [PIXEL_W-1:0] shade(input logic [PIXEL_W-1:0] px,
                                                input logic [CHAN_W-1:0]  k);
      return {ALPHA_OPAQUE,
              scale_chan(px[23:16], k),
              scale_chan(px[15:8], k),
              scale_chan(px[7:0], k)};
   endfunction

endpackage

// ===== src/pru_line_ram.sv =====
// Single-port line buffer with registered read data.
// Generic; depends on nothing.
module pru_line_ram #(
   parameter int DEPTH  = 512,
   parameter int DATA_W = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/pru_seq.sv =====
// Configuration registers and column / row position counters.
// Depends on pru_pkg.
module pru_seq
   import pru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  step,
   output slot_type              slot
);

   localparam int COL_CNT_W = COL_W + 1;
   localparam int ROW_CNT_W = ROW_W + 1;

   logic [CFG_SCALE_W-1:0]  scale_ff, scale_in;
   logic [CFG_WIDTH_W-1:0]  width_ff, width_in;
   logic [CFG_HEIGHT_W-1:0] height_ff, height_in;
   logic [CFG_KEEP_W-1:0]   keep_ff, keep_in;

   logic [COL_W-1:0]       col_ff, col_in;
   logic [CFG_SCALE_W-1:0] rc_ff, rc_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic                   odd_ff, odd_in;

   logic [SCALE_W-1:0]   scale_eff;
   logic [COL_CNT_W-1:0] width_eff;
   logic [ROW_CNT_W-1:0] height_eff;
   logic [COL_CNT_W-1:0] col_inc;
   logic [CFG_SCALE_W:0] rc_inc;
   logic [ROW_CNT_W-1:0] row_inc;

   assign csr_ready = 1'b1;

   always_comb begin
      scale_in  = scale_ff;
      width_in  = width_ff;
      height_in = height_ff;
      keep_in   = keep_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            CSR_SCALE:  scale_in  = csr_data[CFG_SCALE_W-1:0];
            CSR_WIDTH:  width_in  = csr_data[CFG_WIDTH_W-1:0];
            CSR_HEIGHT: height_in = csr_data[CFG_HEIGHT_W-1:0];
            CSR_KEEP:   keep_in   = csr_data[CFG_KEEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero acts as one; large values saturate.
   always_comb begin
      if (scale_ff == '0) begin
         scale_eff = SCALE_W'(1);
      end else if (32'(scale_ff) > 32'(MAX_SCALE)) begin
         scale_eff = SCALE_W'(MAX_SCALE);
      end else begin
         scale_eff = SCALE_W'(scale_ff);
      end
      if (width_ff == '0) begin
         width_eff = COL_CNT_W'(1);
      end else if (32'(width_ff) > 32'(MAX_LINE_WIDTH)) begin
         width_eff = COL_CNT_W'(MAX_LINE_WIDTH);
      end else begin
         width_eff = COL_CNT_W'(width_ff);
      end
      if (height_ff == '0) begin
         height_eff = ROW_CNT_W'(1);
      end else if (32'(height_ff) > 32'(ROW_LIMIT)) begin
         height_eff = ROW_CNT_W'(ROW_LIMIT);
      end else begin
         height_eff = ROW_CNT_W'(height_ff);
      end
   end

   always_comb begin
      col_inc = {1'b0, col_ff} + COL_CNT_W'(1);
      rc_inc  = {1'b0, rc_ff} + (CFG_SCALE_W + 1)'(1);
      row_inc = {1'b0, row_ff} + ROW_CNT_W'(1);
      col_in  = col_ff;
      rc_in   = rc_ff;
      row_in  = row_ff;
      odd_in  = odd_ff;
      if (step) begin
         if (col_inc >= width_eff) begin
            col_in = '0;
            odd_in = ~odd_ff;
            if (32'(rc_inc) >= 32'(scale_eff)) begin
               rc_in = '0;
               if (row_inc >= height_eff) begin
                  row_in = '0;
                  odd_in = 1'b0;
               end else begin
                  row_in = row_inc[ROW_W-1:0];
               end
            end else begin
               rc_in = rc_inc[CFG_SCALE_W-1:0];
            end
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= CFG_SCALE_W'(2);
         width_ff  <= CFG_WIDTH_W'(256);
         height_ff <= CFG_HEIGHT_W'(240);
         keep_ff   <= CFG_KEEP_W'(256);
         col_ff    <= '0;
         rc_ff     <= '0;
         row_ff    <= '0;
         odd_ff    <= 1'b0;
      end else begin
         scale_ff  <= scale_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         keep_ff   <= keep_in;
         col_ff    <= col_in;
         rc_ff     <= rc_in;
         row_ff    <= row_in;
         odd_ff    <= odd_in;
      end
   end

   always_comb begin
      slot.col    = col_ff;
      slot.dark   = odd_ff & ~keep_ff[CFG_KEEP_W-1];
      slot.keep   = keep_ff[CHAN_W-1:0];
      slot.copies = scale_eff;
   end

endmodule

// ===== src/pru_emit.sv =====
// Output side: waits out the line buffer read, applies scanline shading and
// repeats each pixel. Depends on pru_pkg.
module pru_emit
   import pru_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   output logic               take_ready,
   input  logic               mode,
   input  logic [PIXEL_W-1:0] pixel_in,
   input  slot_type           slot,
   input  logic [PIXEL_W-1:0] rdata,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   // Stage 1: buffer read in flight.
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_mode_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   slot_type           s1_slot_ff;

   // Stage 2: pixel, shaded on dark rows, being repeated.
   logic               s2_valid_ff, s2_valid_in;
   logic [PIXEL_W-1:0] s2_pixel_ff, s2_pixel_in;
   logic [SCALE_W-1:0] s2_copies_ff;
   logic [SCALE_W-1:0] s2_cnt_ff, s2_cnt_in;

   logic               s2_last;
   logic               s2_done;
   logic               s1_move;
   logic [PIXEL_W-1:0] src_px;

   assign s2_last    = ({1'b0, s2_cnt_ff} + (SCALE_W + 1)'(1)) == {1'b0, s2_copies_ff};
   assign s2_done    = s2_valid_ff & rsp_ready & s2_last;
   assign s1_move    = s1_valid_ff & (~s2_valid_ff | s2_done);
   assign take_ready = ~s1_valid_ff | s1_move;

   always_comb begin
      src_px      = s1_mode_ff ? rdata : s1_pixel_ff;
      s2_pixel_in = s1_slot_ff.dark ? shade(src_px, s1_slot_ff.keep) : src_px;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      s2_cnt_in   = s2_cnt_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
         s2_cnt_in   = '0;
      end else if (s2_done) begin
         s2_valid_in = 1'b0;
      end else if (s2_valid_ff && rsp_ready) begin
         s2_cnt_in = s2_cnt_ff + SCALE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_cnt_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s2_cnt_ff   <= s2_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_mode_ff  <= mode;
         s1_pixel_ff <= pixel_in;
         s1_slot_ff  <= slot;
      end
      if (s1_move) begin
         s2_pixel_ff  <= s2_pixel_in;
         s2_copies_ff <= s1_slot_ff.copies;
      end
   end

   assign rsp_valid          = s2_valid_ff;
   assign rsp_data.pixel_out = s2_pixel_ff;
   assign rsp_data.last      = s2_last;

endmodule

// ===== src/pixel_replicate_upscaler_scanline_top.sv =====
// Top level of the pixel replicate upscaler with scanline shading.
// Depends on pru_pkg, pru_line_ram, pru_seq and pru_emit.
//
//   channel  dir  handshake                 payload
//   req      in   req_valid / req_ready     req_data  (req_type: mode, pixel_in)
//   rsp      out  rsp_valid / rsp_ready     rsp_data  (rsp_type: pixel_out, last)
//   csr      in   csr_valid / csr_ready     csr_index, csr_data
//
// Each beat in gives scale_factor beats out, one per cycle while rsp_ready
// is high; the output stage repeat counter paces req, and a new beat can be
// taken while the last is repeated if the read stage is free. A beat passes
// the line buffer read, then the output register. csr is always ready.
// Synchronous reset clears counters and pipeline valids and loads config
// defaults; the line buffer is not cleared. A stalled rsp holds the output
// stage and back-pressures req once the read stage is also occupied.
module pixel_replicate_upscaler_scanline_top
   import pru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic               take;
   logic               take_ready;
   slot_type           slot;
   logic [PIXEL_W-1:0] rdata;

   assign req_ready = take_ready;
   assign take      = req_valid & take_ready;

   pru_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .step      (take),
      .slot      (slot)
   );

   // Write new pixels, read for replays.
   pru_line_ram #(
      .DEPTH  (MAX_LINE_WIDTH),
      .DATA_W (PIXEL_W),
      .ADDR_W (COL_W)
   ) u_line_ram (
      .clock (clock),
      .en    (take),
      .we    (~req_data.mode),
      .addr  (slot.col),
      .wdata (req_data.pixel_in),
      .rdata (rdata)
   );

   pru_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .take_ready (take_ready),
      .mode       (req_data.mode),
      .pixel_in   (req_data.pixel_in),
      .slot       (slot),
      .rdata      (rdata),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
